>>> hw/rtl/fcv_pkg.sv
// Shared types and constants for the frame check value block.
package fcv_pkg;

    typedef enum logic [1:0] {
        MODE_CRC16 = 2'd0,
        MODE_LRC   = 2'd1,
        MODE_XOR   = 2'd2,
        MODE_SUM   = 2'd3
    } check_mode_t;

    typedef enum logic [1:0] {
        REG_CHECK_MODE = 2'd0,
        REG_CRC_POLY   = 2'd1,
        REG_CRC_INIT   = 2'd2
    } reg_index_t;

    localparam int unsigned CRC_W   = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [CRC_W-1:0] CRC_POLY_RESET = 16'hA001;
    localparam logic [CRC_W-1:0] CRC_INIT_RESET = 16'hFFFF;

endpackage

>>> hw/rtl/fcv_crc_step.sv
// Reflected CRC-16 update over one byte, eight bit steps unrolled.
module fcv_crc_step
(
    input  logic [fcv_pkg::CRC_W-1:0]  crc_in,
    input  logic [fcv_pkg::BYTE_W-1:0] data_in,
    input  logic [fcv_pkg::CRC_W-1:0]  poly,
    output logic [fcv_pkg::CRC_W-1:0]  crc_out
);

    always_comb
    begin
        logic [fcv_pkg::CRC_W-1:0] crc;
        crc = crc_in ^ {{(fcv_pkg::CRC_W - fcv_pkg::BYTE_W){1'b0}}, data_in};
        for (int k = 0; k < fcv_pkg::BYTE_W; k++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ poly;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        crc_out = crc;
    end

endmodule

>>> hw/rtl/frame_check_value_multi_mode_core.sv
// Top level: frame check value generator with CRC-16, LRC, XOR and sum modes.
//
// Frame bytes enter on the input channel, one transfer per byte, with
// last_byte set on the final byte; each frame yields one check_value transfer.
// The block takes one byte per cycle when the output side keeps up: a byte is
// registered at the input, folded into the accumulators through the unrolled
// eight-bit CRC step as it leaves the input register, and a frame's result is
// stored in the output register when the last byte advances, raising out_valid.
// While a result waits in the output register, a following last byte holds in
// the input register and the input stalls.
// Mode, polynomial and initial value sit in APB registers at 0x0, 0x4 and 0x8;
// the initial value is loaded on the first byte of every frame.
module frame_check_value_multi_mode_core
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcv_pkg::ADDR_W-1:0]    paddr,
    input  logic [fcv_pkg::DATA_W-1:0]    pwdata,
    output logic [fcv_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fcv_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          last_byte,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fcv_pkg::CRC_W-1:0]     check_value
);

    fcv_pkg::check_mode_t              check_mode_reg;
    logic [fcv_pkg::CRC_W-1:0]         crc_poly_reg;
    logic [fcv_pkg::CRC_W-1:0]         crc_init_reg;

    logic                              in_valid_reg;
    logic [fcv_pkg::BYTE_W-1:0]        in_data_reg;
    logic                              in_last_reg;

    logic                              in_frame_reg;
    logic [fcv_pkg::CRC_W-1:0]         crc_acc_reg;
    logic [fcv_pkg::BYTE_W-1:0]        byte_acc_reg;

    logic                              out_valid_reg;
    logic [fcv_pkg::CRC_W-1:0]         out_value_reg;

    logic                              cfg_write;
    fcv_pkg::reg_index_t               cfg_index;
    logic                              out_free;
    logic                              advance;
    logic [fcv_pkg::CRC_W-1:0]         crc_base;
    logic [fcv_pkg::BYTE_W-1:0]        byte_base;
    logic [fcv_pkg::CRC_W-1:0]         crc_next;
    logic [fcv_pkg::BYTE_W-1:0]        byte_next;
    logic [fcv_pkg::BYTE_W-1:0]        lrc_value;
    logic [fcv_pkg::CRC_W-1:0]         value_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = fcv_pkg::reg_index_t'(paddr[fcv_pkg::ADDR_W-1:2]);

    always_comb
    begin
        case (cfg_index)
            fcv_pkg::REG_CHECK_MODE: prdata = {30'd0, check_mode_reg};
            fcv_pkg::REG_CRC_POLY:   prdata = {16'd0, crc_poly_reg};
            fcv_pkg::REG_CRC_INIT:   prdata = {16'd0, crc_init_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_mode_reg <= fcv_pkg::MODE_CRC16;
            crc_poly_reg   <= fcv_pkg::CRC_POLY_RESET;
            crc_init_reg   <= fcv_pkg::CRC_INIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fcv_pkg::REG_CHECK_MODE:
                    check_mode_reg <= fcv_pkg::check_mode_t'(pwdata[1:0]);
                fcv_pkg::REG_CRC_POLY:
                    crc_poly_reg <= pwdata[fcv_pkg::CRC_W-1:0];
                fcv_pkg::REG_CRC_INIT:
                    crc_init_reg <= pwdata[fcv_pkg::CRC_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // hold a last byte only while the result register stays full
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign in_ready = !in_valid_reg || advance;

    assign crc_base  = in_frame_reg ? crc_acc_reg : crc_init_reg;
    assign byte_base = in_frame_reg ? byte_acc_reg : '0;

    fcv_crc_step u_crc_step
    (
        .crc_in  (crc_base),
        .data_in (in_data_reg),
        .poly    (crc_poly_reg),
        .crc_out (crc_next)
    );

    assign byte_next = (check_mode_reg == fcv_pkg::MODE_XOR) ? (byte_base ^ in_data_reg)
                                                             : (byte_base + in_data_reg);
    assign lrc_value = (~byte_next) + 8'd1;

    always_comb
    begin
        case (check_mode_reg)
            fcv_pkg::MODE_CRC16: value_next = {crc_next[7:0], crc_next[15:8]};
            fcv_pkg::MODE_LRC:   value_next = {8'd0, lrc_value};
            default:             value_next = {8'd0, byte_next};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_frame_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                in_frame_reg <= !in_last_reg;
            end
            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (advance)
        begin
            crc_acc_reg  <= crc_next;
            byte_acc_reg <= byte_next;
        end
        if (advance && in_last_reg)
        begin
            out_value_reg <= value_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign check_value = out_value_reg;

`ifndef SYNTHESIS
    a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> !in_frame_reg)
        else $error("frame state not cleared after last byte");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("result raised without a last byte");

    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && in_last_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a full result register");
`endif

endmodule

>>> verif/frame_check_value_monitor.sv
`timescale 1ns / 100ps
// Channel monitor: mirrors the registers, predicts each frame's check value and compares.
module frame_check_value_monitor
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [fcv_pkg::ADDR_W-1:0]    paddr,
    input  logic [fcv_pkg::DATA_W-1:0]    pwdata,

    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [fcv_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          last_byte,

    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [fcv_pkg::CRC_W-1:0]     check_value,

    output int                            mismatch_count,
    output int                            expected_pending,
    output int                            values_checked
);

    fcv_pkg::check_mode_t        mode_q;
    logic [fcv_pkg::CRC_W-1:0]   poly_q;
    logic [fcv_pkg::CRC_W-1:0]   init_q;
    logic [fcv_pkg::CRC_W-1:0]   crc_run;
    logic [fcv_pkg::BYTE_W-1:0]  sum_run;
    logic [fcv_pkg::BYTE_W-1:0]  lrc_run;
    logic                        frame_open;
    logic [fcv_pkg::CRC_W-1:0]   seen_value;
    logic [fcv_pkg::CRC_W-1:0]   check_value_queue[$];

    function automatic logic [fcv_pkg::CRC_W-1:0] crc_fold_byte(
        input logic [fcv_pkg::CRC_W-1:0]  crc,
        input logic [fcv_pkg::BYTE_W-1:0] b,
        input logic [fcv_pkg::CRC_W-1:0]  poly
    );
        logic [fcv_pkg::CRC_W-1:0] c;
        logic                      lsb;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < fcv_pkg::BYTE_W; k++)
        begin
            lsb = c[0];
            c   = c >> 1;
            if (lsb)
                c = c ^ poly;
        end
        return c;
    endfunction

    task automatic note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q         = fcv_pkg::MODE_CRC16;
            poly_q         = fcv_pkg::CRC_POLY_RESET;
            init_q         = fcv_pkg::CRC_INIT_RESET;
            crc_run        = '0;
            sum_run        = '0;
            frame_open     = 1'b0;
            mismatch_count = 0;
            values_checked = 0;
            check_value_queue.delete();
        end
        else
        begin
            // retire the oldest expectation first: it belongs to an earlier byte
            if (out_valid && out_ready)
            begin
                if (check_value_queue.size() == 0)
                    note_error($sformatf("unexpected check_value transfer %h", check_value));
                else
                begin
                    seen_value = check_value_queue.pop_front();
                    values_checked++;
                    if (check_value !== seen_value)
                        note_error($sformatf("check_value mismatch: expected %h, got %h",
                                             seen_value, check_value));
                end
            end

            if (in_valid && in_ready)
            begin
                if (!frame_open)
                begin
                    crc_run = init_q;
                    sum_run = '0;
                end
                crc_run = crc_fold_byte(crc_run, data_byte, poly_q);
                if (mode_q == fcv_pkg::MODE_XOR)
                    sum_run = sum_run ^ data_byte;
                else
                    sum_run = sum_run + data_byte;
                frame_open = !last_byte;
                if (last_byte)
                begin
                    lrc_run = ~sum_run + 8'd1;
                    case (mode_q)
                        fcv_pkg::MODE_CRC16:
                            check_value_queue.push_back({crc_run[7:0], crc_run[15:8]});
                        fcv_pkg::MODE_LRC:
                            check_value_queue.push_back({8'h00, lrc_run});
                        default:
                            check_value_queue.push_back({8'h00, sum_run});
                    endcase
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    fcv_pkg::REG_CHECK_MODE: mode_q = fcv_pkg::check_mode_t'(pwdata[1:0]);
                    fcv_pkg::REG_CRC_POLY:   poly_q = pwdata[fcv_pkg::CRC_W-1:0];
                    fcv_pkg::REG_CRC_INIT:   init_q = pwdata[fcv_pkg::CRC_W-1:0];
                    default:                 ;
                endcase
            end
        end
        expected_pending = check_value_queue.size();
    end

endmodule

>>> verif/frame_check_value_multi_mode_core_test.sv
`timescale 1ns / 100ps
// Testbench top: byte stimulus, register setup, output back-pressure and the verdict.
module frame_check_value_multi_mode_core_test;

    localparam logic [1:0] REG_SPARE   = 2'd3;
    localparam int         NUM_PHASES  = 8;
    localparam int         PHASE_BYTES = 80;
    localparam int         SQUEEZE_PH  = 2;
    localparam int         LONG_HOLD   = 400;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [fcv_pkg::ADDR_W-1:0]    paddr;
    logic [fcv_pkg::DATA_W-1:0]    pwdata;
    logic [fcv_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    logic [fcv_pkg::BYTE_W-1:0]    data_byte;
    logic                          last_byte;
    logic                          out_valid;
    logic                          out_ready;
    logic [fcv_pkg::CRC_W-1:0]     check_value;

    int                   mismatch_count;
    int                   expected_pending;
    int                   values_checked;

    logic                 in_taken = 1'b0;
    bit                   idle_on  = 1'b1;
    bit                   hold_req = 1'b0;
    int                   bytes_sent;
    int                   frames_sent;
    int                   config_writes;
    int                   frame_left;

    frame_check_value_multi_mode_core u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .check_value (check_value)
    );

    frame_check_value_monitor u_monitor
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .check_value      (check_value),
        .mismatch_count   (mismatch_count),
        .expected_pending (expected_pending),
        .values_checked   (values_checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        in_taken <= in_valid && in_ready;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_word(input logic [15:0] dflt);
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return dflt;
            default: return 16'($urandom());
        endcase
    endfunction

    // called and returns on a falling edge
    task automatic push_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        do
            @(negedge clk);
        while (!in_taken);
        bytes_sent++;
        if (l)
            frames_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        config_writes++;
    endtask

    // drop valid, drain expected transfers, then cover the pipeline latency
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : out_side
        int seg;
        bit stalled;
        seg     = 0;
        stalled = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                seg      = 0;
            end
            if (seg == 0)
            begin
                stalled = idle_on && ($urandom_range(0, 3) == 0);
                seg     = stalled ? 1 + pick_gap() : $urandom_range(1, 16);
            end
            out_ready <= !stalled;
            seg--;
        end
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : in_side
        int len;
        clk           = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        data_byte     = '0;
        last_byte     = 1'b0;
        out_ready     = 1'b0;
        bytes_sent    = 0;
        frames_sent   = 0;
        config_writes = 0;
        frame_left    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: reflected CRC-16, single-byte frames first
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b1);
        settle();
        write_reg(fcv_pkg::REG_CHECK_MODE, 16'(fcv_pkg::MODE_LRC));
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        settle();
        write_reg(fcv_pkg::REG_CHECK_MODE, 16'(fcv_pkg::MODE_XOR));
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hFF, 1'b1);
        settle();
        write_reg(fcv_pkg::REG_CHECK_MODE, 16'(fcv_pkg::MODE_SUM));
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b1);
        settle();
        write_reg(fcv_pkg::REG_CRC_POLY, 16'h0000);
        write_reg(fcv_pkg::REG_CRC_INIT, 16'h0000);
        write_reg(fcv_pkg::REG_CHECK_MODE, 16'(fcv_pkg::MODE_CRC16));
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        settle();
        write_reg(fcv_pkg::REG_CRC_POLY, 16'hFFFF);
        write_reg(fcv_pkg::REG_CRC_INIT, 16'hFFFF);
        write_reg(fcv_pkg::REG_CHECK_MODE, 16'(fcv_pkg::MODE_XOR));
        push_byte(8'h0F, 1'b0);
        // change every setting inside one frame
        settle();
        write_reg(fcv_pkg::REG_CHECK_MODE, 16'(fcv_pkg::MODE_SUM));
        write_reg(fcv_pkg::REG_CRC_POLY, 16'h8408);
        write_reg(fcv_pkg::REG_CRC_INIT, 16'h1234);
        push_byte(8'hF0, 1'b0);
        settle();
        write_reg(fcv_pkg::REG_CHECK_MODE, 16'(fcv_pkg::MODE_CRC16));
        push_byte(8'h33, 1'b1);
        push_byte(8'h00, 1'b1);
        settle();
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(fcv_pkg::REG_CHECK_MODE, 16'(fcv_pkg::MODE_LRC));
        push_byte(8'h00, 1'b1);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h81, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            idle_on = (ph % 3 != 2);
            write_reg(fcv_pkg::REG_CHECK_MODE, 16'(ph % 4));
            if (ph == 0 || $urandom_range(0, 2) != 0)
                write_reg(fcv_pkg::REG_CRC_POLY, pick_word(fcv_pkg::CRC_POLY_RESET));
            if (ph == 0 || $urandom_range(0, 2) != 0)
                write_reg(fcv_pkg::REG_CRC_INIT, pick_word(fcv_pkg::CRC_INIT_RESET));
            if (ph == SQUEEZE_PH)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_BYTES; n++)
            begin
                if (frame_left == 0)
                begin
                    len = $urandom_range(0, 19);
                    if (ph == SQUEEZE_PH || len < 2)
                        frame_left = 1;
                    else if (len < 17)
                        frame_left = $urandom_range(2, 8);
                    else
                        frame_left = $urandom_range(9, 40);
                end
                frame_left--;
                push_byte(pick_data(), frame_left == 0);
            end
        end
        idle_on = 1'b1;
        while (frame_left != 0)
        begin
            frame_left--;
            push_byte(pick_data(), frame_left == 0);
        end
        settle();
        repeat (10) @(negedge clk);

        $display("Sent %0d bytes in %0d frames with %0d register writes.",
                 bytes_sent, frames_sent, config_writes);
        $display("Compared %0d check values over all four modes, setting changes inside",
                 values_checked);
        $display("frames and a long output stall.");
        if (expected_pending != 0)
            $display("%0d expected check values never arrived", expected_pending);
        if (mismatch_count == 0 && expected_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
